// File: design/lndr_pkg.sv
`default_nettype none
package lndr_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_K1     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_K2     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_K3     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INVMAG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RNORM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CX     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CY     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS   = 3'd7;

    localparam logic signed [31:0] WARP_ONE = 32'sh0100_0000;
    localparam logic [7:0]         FRAC_MAX = 8'd255;

    typedef struct packed {
        logic [11:0] out_x;
        logic [11:0] out_y;
    } t_req;

    typedef struct packed {
        logic        inside_res;
        logic [11:0] src_col;
        logic [11:0] src_row;
        logic [25:0] byte_offset;
        logic [7:0]  frac_x;
        logic [7:0]  frac_y;
    } t_res;

    typedef struct packed {
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] k3;
        logic signed [31:0] sc;
        logic [31:0]        rn;
        logic signed [20:0] cx8;
        logic signed [20:0] cy8;
        logic [11:0]        w;
        logic [11:0]        h;
        logic [11:0]        xlim;
        logic [11:0]        ylim;
        logic               identity;
    } t_cfg;

    typedef struct packed {
        logic               beyond;
        logic [11:0]        x;
        logic [11:0]        y;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
    } t_tok;

    function automatic logic signed [31:0] sat_d(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > 37'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (v < -37'sd2147483647) begin
            r = 32'sh8000_0001;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
        logic signed [31:0] r;
        if (v > 41'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (v < -41'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: design/lndr_cfg.sv
`default_nettype none
module lndr_cfg (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_valid,
    input  wire [lndr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [31:0]                      i_cfg_data,
    output logic                            o_cfg_ready,
    output lndr_pkg::t_cfg                  o_cfg
);
    import lndr_pkg::*;

    logic [31:0] r_k1, r_k2, r_k3, r_sc, r_rn;
    logic [20:0] r_cx, r_cy;
    logic [23:0] r_dims;
    logic        n_cdef;
    logic [11:0] n_xlim, n_ylim;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1   <= 32'd0;
            r_k2   <= 32'd0;
            r_k3   <= 32'd0;
            r_sc   <= 32'h0100_0000;
            r_rn   <= 32'd0;
            r_cx   <= 21'd0;
            r_cy   <= 21'd0;
            r_dims <= 24'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_K1:     r_k1   <= i_cfg_data;
                REG_K2:     r_k2   <= i_cfg_data;
                REG_K3:     r_k3   <= i_cfg_data;
                REG_INVMAG: r_sc   <= i_cfg_data;
                REG_RNORM:  r_rn   <= i_cfg_data;
                REG_CX:     r_cx   <= i_cfg_data[20:0];
                REG_CY:     r_cy   <= i_cfg_data[20:0];
                REG_DIMS:   r_dims <= i_cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_xlim = r_dims[11:0] - 12'd1;
        n_ylim = r_dims[23:12] - 12'd1;
        n_cdef = r_cx[20] || (r_cx == 21'd0) || r_cy[20] || (r_cy == 21'd0);
        o_cfg.k1   = $signed(r_k1);
        o_cfg.k2   = $signed(r_k2);
        o_cfg.k3   = $signed(r_k3);
        o_cfg.sc   = $signed(r_sc);
        o_cfg.rn   = r_rn;
        o_cfg.cx8  = n_cdef ? $signed({2'b0, n_xlim, 7'b0}) : $signed(r_cx);
        o_cfg.cy8  = n_cdef ? $signed({2'b0, n_ylim, 7'b0}) : $signed(r_cy);
        o_cfg.w    = r_dims[11:0];
        o_cfg.h    = r_dims[23:12];
        o_cfg.xlim = n_xlim;
        o_cfg.ylim = n_ylim;
        o_cfg.identity = r_sc[31] || (r_sc == 32'd0) ||
                         (($signed(r_sc) == WARP_ONE) && (r_k1 == 32'd0) &&
                          (r_k2 == 32'd0) && (r_k3 == 32'd0));
    end

endmodule
`default_nettype wire

// File: design/lndr_radius.sv
`default_nettype none
module lndr_radius (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  lndr_pkg::t_cfg       i_cfg,
    input  wire                  i_valid,
    input  lndr_pkg::t_req       i_req,
    output logic                 o_valid,
    output lndr_pkg::t_tok       o_tok,
    output logic [30:0]          o_r2
);
    import lndr_pkg::*;

    logic [6:0]         r_vld;
    t_tok               r_tok [7];
    logic signed [20:0] r_px, r_py;
    logic signed [52:0] r_mx, r_my;
    logic [61:0]        r_sqx, r_sqy;
    logic [62:0]        r_sq;
    logic [62:0]        r_phi;
    logic [63:0]        r_plo;
    logic [30:0]        r_r2;
    logic signed [63:0] n_sqx, n_sqy;
    logic [63:0]        n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 7'd0;
        end else begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    always_comb begin
        n_sqx = r_tok[2].dx * r_tok[2].dx;
        n_sqy = r_tok[2].dy * r_tok[2].dy;
        n_acc = {1'b0, r_phi} + {32'd0, r_plo[63:32]};
    end

    always_ff @(posedge i_clk) begin
        r_tok[0].beyond <= (i_req.out_x >= i_cfg.w) || (i_req.out_y >= i_cfg.h);
        r_tok[0].x      <= i_req.out_x;
        r_tok[0].y      <= i_req.out_y;
        r_tok[0].dx     <= 32'sd0;
        r_tok[0].dy     <= 32'sd0;
        r_px <= $signed({1'b0, i_req.out_x, 8'b0}) - $signed({2'b0, i_cfg.xlim, 7'b0});
        r_py <= $signed({1'b0, i_req.out_y, 8'b0}) - $signed({2'b0, i_cfg.ylim, 7'b0});

        r_tok[1] <= r_tok[0];
        r_mx <= i_cfg.sc * r_px;
        r_my <= i_cfg.sc * r_py;

        r_tok[2].beyond <= r_tok[1].beyond;
        r_tok[2].x      <= r_tok[1].x;
        r_tok[2].y      <= r_tok[1].y;
        r_tok[2].dx     <= sat_d($signed(r_mx[52:16]));
        r_tok[2].dy     <= sat_d($signed(r_my[52:16]));

        r_tok[3] <= r_tok[2];
        r_sqx <= n_sqx[61:0];
        r_sqy <= n_sqy[61:0];

        r_tok[4] <= r_tok[3];
        r_sq <= {1'b0, r_sqx} + {1'b0, r_sqy};

        r_tok[5] <= r_tok[4];
        r_phi <= r_sq[62:32] * i_cfg.rn;
        r_plo <= r_sq[31:0] * i_cfg.rn;

        r_tok[6] <= r_tok[5];
        r_r2 <= (n_acc[63:39] != 25'd0) ? 31'h7fff_ffff : n_acc[38:8];
    end

    assign o_valid = r_vld[6];
    assign o_tok   = r_tok[6];
    assign o_r2    = r_r2;

endmodule
`default_nettype wire

// File: design/lndr_warp.sv
`default_nettype none
module lndr_warp (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  lndr_pkg::t_cfg       i_cfg,
    input  wire                  i_valid,
    input  lndr_pkg::t_tok       i_tok,
    input  wire [30:0]           i_r2,
    output logic                 o_valid,
    output lndr_pkg::t_tok       o_tok,
    output logic signed [31:0]   o_warp
);
    import lndr_pkg::*;

    logic [5:0]         r_vld;
    t_tok               r_tok [6];
    logic [30:0]        r_r2  [4];
    logic signed [63:0] r_m3, r_m2, r_m1;
    logic signed [31:0] r_t2, r_t1, r_t0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 6'd0;
        end else begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok[0] <= i_tok;
        r_r2[0]  <= i_r2;
        for (int i = 1; i < 6; i++) begin
            r_tok[i] <= r_tok[i-1];
        end
        for (int i = 1; i < 4; i++) begin
            r_r2[i] <= r_r2[i-1];
        end
        r_m3 <= i_cfg.k3 * $signed({1'b0, i_r2});
        r_t2 <= sat32($signed({{9{i_cfg.k2[31]}}, i_cfg.k2}) +
                      $signed({r_m3[63], r_m3[63:24]}));
        r_m2 <= r_t2 * $signed({1'b0, r_r2[1]});
        r_t1 <= sat32($signed({{9{i_cfg.k1[31]}}, i_cfg.k1}) +
                      $signed({r_m2[63], r_m2[63:24]}));
        r_m1 <= r_t1 * $signed({1'b0, r_r2[3]});
        r_t0 <= sat32($signed({{9{WARP_ONE[31]}}, WARP_ONE}) +
                      $signed({r_m1[63], r_m1[63:24]}));
    end

    assign o_valid = r_vld[5];
    assign o_tok   = r_tok[5];
    assign o_warp  = r_t0;

endmodule
`default_nettype wire

// File: design/lndr_addr.sv
`default_nettype none
module lndr_addr (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  lndr_pkg::t_cfg       i_cfg,
    input  wire                  i_valid,
    input  lndr_pkg::t_tok       i_tok,
    input  wire signed [31:0]    i_warp,
    output logic                 o_valid,
    output lndr_pkg::t_res       o_res
);
    import lndr_pkg::*;

    logic [3:0]         r_vld;
    t_tok               r_tok;
    logic signed [63:0] r_qx, r_qy;
    logic               r_ins1, r_ins2;
    logic [11:0]        r_col1, r_row1, r_col2, r_row2;
    logic [7:0]         r_fx1, r_fy1, r_fx2, r_fy2;
    logic [23:0]        r_rw;
    t_res               r_res;

    logic signed [40:0] n_wx, n_wy;
    logic [16:0]        n_rx, n_ry;
    logic               n_in;
    t_res               n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 4'd0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_comb begin
        n_wx = $signed({{12{i_cfg.cx8[20]}}, i_cfg.cx8, 8'b0}) +
               $signed({r_qx[63], r_qx[63:24]});
        n_wy = $signed({{12{i_cfg.cy8[20]}}, i_cfg.cy8, 8'b0}) +
               $signed({r_qy[63], r_qy[63:24]});
        n_in = !n_wx[40] && (n_wx < $signed({13'd0, i_cfg.xlim, 16'd0})) &&
               !n_wy[40] && (n_wy < $signed({13'd0, i_cfg.ylim, 16'd0}));
        n_rx = {1'b0, n_wx[15:0]} + 17'd128;
        n_ry = {1'b0, n_wy[15:0]} + 17'd128;
    end

    always_comb begin
        n_res.inside_res  = r_ins2;
        n_res.src_col     = r_col2;
        n_res.src_row     = r_row2;
        n_res.byte_offset = {1'b0, r_rw, 1'b0} + {2'b0, r_rw} +
                            {13'd0, r_col2, 1'b0} + {14'd0, r_col2};
        n_res.frac_x      = r_fx2;
        n_res.frac_y      = r_fy2;
    end

    always_ff @(posedge i_clk) begin
        r_tok <= i_tok;
        r_qx  <= i_warp * i_tok.dx;
        r_qy  <= i_warp * i_tok.dy;

        if (r_tok.beyond) begin
            r_ins1 <= 1'b0;
            r_col1 <= 12'd0;
            r_row1 <= 12'd0;
            r_fx1  <= 8'd0;
            r_fy1  <= 8'd0;
        end else if (i_cfg.identity) begin
            r_ins1 <= 1'b1;
            r_col1 <= r_tok.x;
            r_row1 <= r_tok.y;
            r_fx1  <= 8'd0;
            r_fy1  <= 8'd0;
        end else if (n_in) begin
            r_ins1 <= 1'b1;
            r_col1 <= n_wx[27:16];
            r_row1 <= n_wy[27:16];
            r_fx1  <= n_rx[16] ? FRAC_MAX : n_rx[15:8];
            r_fy1  <= n_ry[16] ? FRAC_MAX : n_ry[15:8];
        end else begin
            r_ins1 <= 1'b0;
            r_col1 <= 12'd0;
            r_row1 <= 12'd0;
            r_fx1  <= 8'd0;
            r_fy1  <= 8'd0;
        end

        r_rw   <= r_row1 * i_cfg.w;
        r_ins2 <= r_ins1;
        r_col2 <= r_col1;
        r_row2 <= r_row1;
        r_fx2  <= r_fx1;
        r_fy2  <= r_fy1;

        r_res <= n_res;
    end

    assign o_valid = r_vld[3];
    assign o_res   = r_res;

endmodule
`default_nettype wire

// File: design/lens_distortion_remap.sv
// Throughput: one request per clock; busy stays low, the pipeline never stalls.
// Every one of the 17 register stages (offset, radius, Horner, sample) takes a new request each clock.
// Reset (synchronous, active low) clears the stage valid bits and restores the config registers only.
// The result strobe is high for one cycle per request; the receiver cannot hold it off.
`default_nettype none
module lens_distortion_remap (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_start,
    output logic                            o_busy,
    input  lndr_pkg::t_req                  i_req,
    output logic                            o_res_valid,
    output lndr_pkg::t_res                  o_res,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [lndr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [31:0]                      i_cfg_data
);
    import lndr_pkg::*;

    t_cfg               cfg;
    logic               rad_vld, wrp_vld;
    t_tok               rad_tok, wrp_tok;
    logic [30:0]        rad_r2;
    logic signed [31:0] wrp_t;

    assign o_busy = 1'b0;

    lndr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    lndr_radius u_radius (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_start && !o_busy),
        .i_req   (i_req),
        .o_valid (rad_vld),
        .o_tok   (rad_tok),
        .o_r2    (rad_r2)
    );

    lndr_warp u_warp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (rad_vld),
        .i_tok   (rad_tok),
        .i_r2    (rad_r2),
        .o_valid (wrp_vld),
        .o_tok   (wrp_tok),
        .o_warp  (wrp_t)
    );

    lndr_addr u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (wrp_vld),
        .i_tok   (wrp_tok),
        .i_warp  (wrp_t),
        .o_valid (o_res_valid),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire
